// ===== sv/integer_to_ascii_formatter_assert.svh =====
// Assertion macros shared by the formatter modules.
// Each macro checks a property on the rising edge of clk, disabled while rstn is low.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define I2A_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define I2A_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define I2A_ASSERT_SAME(name, clk, rstn, ante, cons)
`define I2A_ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

// ===== sv/i2a_pkg.sv =====
package i2a_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int OP_W       = 2;
    localparam int NIB_W      = 4;
    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = VALUE_W / NIB_W;
    localparam int DIGITS_W   = DEC_DIGITS * NIB_W;
    localparam int CNT_W      = 4;
    localparam int STEP_W     = 6;

    // Conversion codes.
    localparam logic [OP_W-1:0] OP_UDEC = 2'd0;
    localparam logic [OP_W-1:0] OP_SDEC = 2'd1;
    localparam logic [OP_W-1:0] OP_LHEX = 2'd2;
    localparam logic [OP_W-1:0] OP_UHEX = 2'd3;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOWA  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UPA   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    // Digits from the converter, aligned so that the most significant digit
    // sits in the top nibble.
    typedef struct packed {
        logic                valid;
        logic [DIGITS_W-1:0] digits;
        logic [CNT_W-1:0]    ndig;
        logic                neg;
        logic                upper;
    } conv_result_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-NIB_W){1'b0}}, d};
        if (d < 4'd10) begin
            digit_char = CH_ZERO + ext;
        end else if (upper) begin
            digit_char = CH_UPA + ext - 8'd10;
        end else begin
            digit_char = CH_LOWA + ext - 8'd10;
        end
    endfunction

endpackage

// ===== sv/integer_to_ascii_formatter.sv =====
// Integer to ASCII formatter. Each input beat carries a 32-bit value on s_tdata and a
// conversion code on s_tuser (unsigned decimal, signed decimal, lowercase hex, uppercase
// hex); the block answers with the value's text, one character per output beat, most
// significant first, with m_tlast on the final character. Negative signed values get a
// leading '-'; zero prints as "0"; there is no padding. Items are handled one at a time.
// Decimal conversion runs a shift-add-3 unit one binary bit per cycle; hex needs no
// shifting. Leading zeros are then dropped one digit per cycle (up to 9 for decimal, 7
// for hex), then the skip ends; the '-' leaves as soon as the output register is free,
// even while zeros are still being dropped, and one character leaves per cycle while
// m_tready is high. Dropped zeros and printed digits together always cover every digit
// position, so with m_tready held high the gap between accepted input beats depends on
// the code, not the digits; cycles in which m_tready holds back a character can add to it.
// The next input beat is taken once the final character of the current one has moved
// into the output register.

module integer_to_ascii_formatter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [i2a_pkg::VALUE_W-1:0]    s_tdata,   // [31:0] value
    input  logic [i2a_pkg::OP_W-1:0]       s_tuser,   // [1:0] opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [i2a_pkg::CHAR_W-1:0]     m_tdata,   // [7:0] character
    output logic                           m_tlast
);

    logic                          conv_busy;
    logic                          emit_busy;
    logic                          start;
    logic                          is_neg;
    logic                          is_hex;
    logic                          is_upper;
    logic [i2a_pkg::VALUE_W-1:0]   mag;
    i2a_pkg::conv_result_t         conv;

    assign s_tready = !conv_busy && !emit_busy;
    assign start    = s_tvalid && s_tready;

    assign is_neg   = (s_tuser == i2a_pkg::OP_SDEC) && s_tdata[i2a_pkg::VALUE_W-1];
    assign is_hex   = (s_tuser == i2a_pkg::OP_LHEX) || (s_tuser == i2a_pkg::OP_UHEX);
    assign is_upper = (s_tuser == i2a_pkg::OP_UHEX);
    // The most negative value wraps to its own bits, which read as 2147483648 unsigned.
    assign mag      = is_neg ? (~s_tdata + 1'b1) : s_tdata;

    i2a_bin2bcd u_bin2bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .mag     (mag),
        .hex     (is_hex),
        .neg     (is_neg),
        .upper   (is_upper),
        .busy    (conv_busy),
        .result  (conv)
    );

    i2a_emitter u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .conv     (conv),
        .busy     (emit_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sv/i2a_bin2bcd.sv =====
`include "integer_to_ascii_formatter_assert.svh"

module i2a_bin2bcd (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [i2a_pkg::VALUE_W-1:0]         mag,
    input  logic                                hex,
    input  logic                                neg,
    input  logic                                upper,
    output logic                                busy,
    output i2a_pkg::conv_result_t               result
);

    logic                          busy_reg, busy_next;
    logic [i2a_pkg::STEP_W-1:0]    steps_reg, steps_next;
    logic [i2a_pkg::VALUE_W-1:0]   bin_reg, bin_next;
    logic [i2a_pkg::DIGITS_W-1:0]  bcd_reg, bcd_next;
    logic                          hex_reg, hex_next;
    logic                          neg_reg, neg_next;
    logic                          upper_reg, upper_next;
    logic [i2a_pkg::DIGITS_W-1:0]  bcd_adj;
    logic                          finish;

    assign finish = busy_reg && (steps_reg == '0);

    // Shift-add-3: every BCD digit of five or more gets three added before
    // the next binary bit is shifted in.
    always_comb begin
        for (int i = 0; i < i2a_pkg::DEC_DIGITS; i++) begin
            if (bcd_reg[i*i2a_pkg::NIB_W +: i2a_pkg::NIB_W] >= 4'd5) begin
                bcd_adj[i*i2a_pkg::NIB_W +: i2a_pkg::NIB_W] =
                    bcd_reg[i*i2a_pkg::NIB_W +: i2a_pkg::NIB_W] + 4'd3;
            end else begin
                bcd_adj[i*i2a_pkg::NIB_W +: i2a_pkg::NIB_W] =
                    bcd_reg[i*i2a_pkg::NIB_W +: i2a_pkg::NIB_W];
            end
        end
    end

    always_comb begin
        busy_next  = busy_reg;
        steps_next = steps_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        hex_next   = hex_reg;
        neg_next   = neg_reg;
        upper_next = upper_reg;
        if (start) begin
            busy_next  = 1'b1;
            hex_next   = hex;
            neg_next   = neg;
            upper_next = upper;
            if (hex) begin
                // Hex digits are the nibbles themselves, no steps needed.
                bcd_next   = {mag, {(i2a_pkg::DIGITS_W-i2a_pkg::VALUE_W){1'b0}}};
                steps_next = '0;
            end else begin
                bcd_next   = '0;
                bin_next   = mag;
                steps_next = i2a_pkg::STEP_W'(i2a_pkg::VALUE_W);
            end
        end else if (finish) begin
            busy_next = 1'b0;
        end else if (busy_reg) begin
            bcd_next   = {bcd_adj[i2a_pkg::DIGITS_W-2:0], bin_reg[i2a_pkg::VALUE_W-1]};
            bin_next   = {bin_reg[i2a_pkg::VALUE_W-2:0], 1'b0};
            steps_next = steps_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            steps_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            steps_reg <= steps_next;
        end
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        hex_reg   <= hex_next;
        neg_reg   <= neg_next;
        upper_reg <= upper_next;
    end

    assign busy          = busy_reg;
    assign result.valid  = finish;
    assign result.digits = bcd_reg;
    assign result.ndig   = hex_reg ? i2a_pkg::CNT_W'(i2a_pkg::HEX_DIGITS)
                                   : i2a_pkg::CNT_W'(i2a_pkg::DEC_DIGITS);
    assign result.neg    = neg_reg;
    assign result.upper  = upper_reg;

    `I2A_ASSERT_NEXT(a_finish_clears_busy, aclk, aresetn, finish && !start, !busy_reg)
    `I2A_ASSERT_SAME(a_no_start_while_busy, aclk, aresetn, start, !busy_reg)

endmodule

// ===== sv/i2a_emitter.sv =====
`include "integer_to_ascii_formatter_assert.svh"

module i2a_emitter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  i2a_pkg::conv_result_t         conv,
    output logic                          busy,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [i2a_pkg::CHAR_W-1:0]    m_tdata,
    output logic                          m_tlast
);

    logic                          busy_reg, busy_next;
    logic                          skip_reg, skip_next;
    logic                          sign_reg, sign_next;
    logic                          upper_reg, upper_next;
    logic [i2a_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [i2a_pkg::DIGITS_W-1:0]  digits_reg, digits_next;
    logic                          out_valid_reg, out_valid_next;
    logic [i2a_pkg::CHAR_W-1:0]    char_reg, char_next;
    logic                          last_reg, last_next;
    logic [i2a_pkg::NIB_W-1:0]     top_nib;
    logic                          out_free;
    logic                          emit_last;

    assign top_nib  = digits_reg[i2a_pkg::DIGITS_W-1 -: i2a_pkg::NIB_W];
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        busy_next      = busy_reg;
        skip_next      = skip_reg;
        sign_next      = sign_reg;
        upper_next     = upper_reg;
        cnt_next       = cnt_reg;
        digits_next    = digits_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        emit_last      = 1'b0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (conv.valid) begin
            busy_next   = 1'b1;
            skip_next   = 1'b1;
            sign_next   = conv.neg;
            upper_next  = conv.upper;
            cnt_next    = conv.ndig;
            digits_next = conv.digits;
        end else if (busy_reg) begin
            // Leading zeros are shifted away one digit a cycle, keeping at
            // least one digit so that zero prints as a single '0'.
            if (skip_reg) begin
                if (top_nib == '0 && cnt_reg > 4'd1) begin
                    digits_next = {digits_reg[i2a_pkg::DIGITS_W-i2a_pkg::NIB_W-1:0],
                                   {i2a_pkg::NIB_W{1'b0}}};
                    cnt_next    = cnt_reg - 1'b1;
                end else begin
                    skip_next = 1'b0;
                end
            end
            if (out_free) begin
                if (sign_reg) begin
                    out_valid_next = 1'b1;
                    char_next      = i2a_pkg::CH_MINUS;
                    last_next      = 1'b0;
                    sign_next      = 1'b0;
                end else if (!skip_reg) begin
                    emit_last      = (cnt_reg == 4'd1);
                    out_valid_next = 1'b1;
                    char_next      = i2a_pkg::digit_char(top_nib, upper_reg);
                    last_next      = emit_last;
                    digits_next    = {digits_reg[i2a_pkg::DIGITS_W-i2a_pkg::NIB_W-1:0],
                                      {i2a_pkg::NIB_W{1'b0}}};
                    cnt_next       = cnt_reg - 1'b1;
                    if (emit_last) begin
                        busy_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            skip_reg      <= 1'b0;
            sign_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            skip_reg      <= skip_next;
            sign_reg      <= sign_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
        upper_reg  <= upper_next;
        digits_reg <= digits_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign busy     = busy_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;

    `I2A_ASSERT_SAME(a_load_when_idle, aclk, aresetn, conv.valid, !busy_reg)
    `I2A_ASSERT_SAME(a_count_live, aclk, aresetn, busy_reg, cnt_reg != '0)
    `I2A_ASSERT_NEXT(a_last_ends_item, aclk, aresetn, emit_last, !busy_reg && m_tlast)

endmodule

// ===== test/integer_to_ascii_formatter_tb.sv =====
`timescale 1ns / 100ps

module integer_to_ascii_formatter_tb;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 60;
    localparam int REPORT_LIMIT   = 20;
    localparam logic [i2a_pkg::CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    typedef struct packed {
        logic [i2a_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } text_char_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [i2a_pkg::VALUE_W-1:0]   s_tdata = '0;
    logic [i2a_pkg::OP_W-1:0]      s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [i2a_pkg::CHAR_W-1:0]    m_tdata;
    logic                          m_tlast;

    text_char_t expected_chars[$];
    int         mismatch_count = 0;
    int         quiet_cycles = 0;
    bit         steady_flow = 1'b0;

    integer_to_ascii_formatter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Builds the text of one value, most significant character first.
    function automatic void predict_text(input logic [i2a_pkg::OP_W-1:0] op,
                                         input logic [i2a_pkg::VALUE_W-1:0] value);
        logic [i2a_pkg::VALUE_W-1:0] magnitude;
        logic [i2a_pkg::VALUE_W-1:0] radix;
        logic [3:0]                  digit;
        logic [i2a_pkg::CHAR_W-1:0]  digit_text[$];
        text_char_t                  entry;
        bit                          negative;
        magnitude = value;
        negative = 1'b0;
        radix = (op == i2a_pkg::OP_LHEX || op == i2a_pkg::OP_UHEX) ? 32'd16 : 32'd10;
        if (op == i2a_pkg::OP_SDEC && value[i2a_pkg::VALUE_W-1]) begin
            negative = 1'b1;
            magnitude = ~value + 32'd1;
        end
        do begin
            digit = 4'(magnitude % radix);
            if (digit < 4'd10) begin
                digit_text.push_front(8'h30 + i2a_pkg::CHAR_W'(digit));
            end else if (op == i2a_pkg::OP_UHEX) begin
                digit_text.push_front(8'h41 + i2a_pkg::CHAR_W'(digit) - 8'd10);
            end else begin
                digit_text.push_front(8'h61 + i2a_pkg::CHAR_W'(digit) - 8'd10);
            end
            magnitude = magnitude / radix;
        end while (magnitude != 0);
        if (negative) begin
            entry.ch = MINUS_CHAR;
            entry.last = 1'b0;
            expected_chars.push_back(entry);
        end
        foreach (digit_text[i]) begin
            entry.ch = digit_text[i];
            entry.last = (i == digit_text.size() - 1);
            expected_chars.push_back(entry);
        end
    endfunction

    task automatic send_value(input logic [i2a_pkg::OP_W-1:0] op,
                              input logic [i2a_pkg::VALUE_W-1:0] value);
        @(negedge aclk);
        if (!steady_flow && $urandom_range(99) < 8) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = value;
        do @(posedge aclk); while (!s_tready);
        predict_text(op, value);
    endtask

    task automatic wait_for_drain();
        while (expected_chars.size() != 0) @(posedge aclk);
    endtask

    // The receiver stalls at random unless a steady stretch is running.
    always @(negedge aclk) begin
        m_tready = steady_flow || ($urandom_range(99) >= 8);
    end

    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected beat: expected none, actual char %h last %b",
                             $time, m_tdata, m_tlast);
            end else begin
                want = expected_chars.pop_front();
                if (m_tdata !== want.ch) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: character mismatch: expected %h, actual %h",
                                 $time, want.ch, m_tdata);
                end
                if (m_tlast !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: last flag mismatch: expected %b, actual %b",
                                 $time, want.last, m_tlast);
                end
            end
        end
    end

    // Counts cycles without any accepted beat on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d characters outstanding",
                     $time, expected_chars.size());
            $display("integer_to_ascii_formatter_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_directed();
        logic [i2a_pkg::OP_W-1:0] op;
        for (int k = 0; k < 4; k++) begin
            op = i2a_pkg::OP_W'(k);
            send_value(op, 32'h0000_0000);
            send_value(op, 32'hFFFF_FFFF);
        end
        send_value(i2a_pkg::OP_SDEC, 32'h8000_0000);
        send_value(i2a_pkg::OP_SDEC, 32'h7FFF_FFFF);
        send_value(i2a_pkg::OP_UDEC, 32'h8000_0000);
        send_value(i2a_pkg::OP_SDEC, 32'd1);
        send_value(i2a_pkg::OP_UDEC, 32'd9);
        send_value(i2a_pkg::OP_UDEC, 32'd10);
        send_value(i2a_pkg::OP_UDEC, 32'd1000000000);
        send_value(i2a_pkg::OP_SDEC, 32'hFFFF_FFF6);
        send_value(i2a_pkg::OP_LHEX, 32'h0000_000A);
        send_value(i2a_pkg::OP_UHEX, 32'h0000_000A);
        send_value(i2a_pkg::OP_LHEX, 32'hDEAD_BEEF);
        send_value(i2a_pkg::OP_UHEX, 32'hDEAD_BEEF);
        send_value(i2a_pkg::OP_LHEX, 32'h1000_0000);
        send_value(i2a_pkg::OP_UHEX, 32'h0123_4567);
        send_value(i2a_pkg::OP_LHEX, 32'h89AB_CDEF);
    endtask

    task automatic test_random(input int count);
        logic [i2a_pkg::VALUE_W-1:0] value;
        logic [i2a_pkg::VALUE_W-1:0] power;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 4))
                0: value = $urandom_range(0, 20);
                1: value = (32'd1 << $urandom_range(0, 31))
                           - i2a_pkg::VALUE_W'($urandom_range(0, 1));
                2: begin
                    // Values at the edge of a digit count in decimal.
                    power = 32'd1;
                    repeat ($urandom_range(1, 9)) power = power * 32'd10;
                    value = power - i2a_pkg::VALUE_W'($urandom_range(0, 1));
                end
                3: value = -i2a_pkg::VALUE_W'($urandom_range(1, 1000));
                default: value = $urandom;
            endcase
            send_value(i2a_pkg::OP_W'($urandom_range(0, 3)), value);
            // Now and then the sender holds off until the text has drained.
            if (n % 50 == 49) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                wait_for_drain();
            end
        end
    endtask

    task automatic test_steady_stream(input int count);
        steady_flow = 1'b1;
        for (int n = 0; n < count; n++)
            send_value(i2a_pkg::OP_W'($urandom_range(0, 3)), $urandom);
        steady_flow = 1'b0;
    endtask

    task automatic test_pause_drain();
        send_value(i2a_pkg::OP_SDEC, 32'h8000_0000);
        send_value(i2a_pkg::OP_UDEC, $urandom);
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait_for_drain();
        send_value(i2a_pkg::OP_UHEX, $urandom);
        send_value(i2a_pkg::OP_LHEX, $urandom);
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_random(150);
        test_steady_stream(40);
        test_pause_drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("integer_to_ascii_formatter_tb: PASS");
        end else begin
            $display("integer_to_ascii_formatter_tb: FAIL");
        end
        $finish;
    end

endmodule
